// ===== src/rbs_pkg.sv =====
// Shared constants and register codes for the 2D ray versus box slab test.
`timescale 1ns / 1ps

package rbs_pkg;

  // Default coordinate format: signed Q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Quotient width of one slab division: |edge - origin| needs COORD_WIDTH+1 bits,
  // then FRAC_BITS fraction bits are appended
  localparam int QUO_WIDTH_DEF = COORD_WIDTH_DEF + 1 + FRAC_BITS_DEF;

  // Ray parameter saturation points
  localparam int TCAP_LOG2 = 61;
  localparam int TINF_LOG2 = 62;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BOX_LEFT   = 2'd0,
    REG_BOX_BOTTOM = 2'd1,
    REG_BOX_WIDTH  = 2'd2,
    REG_BOX_HEIGHT = 2'd3
  } cfg_reg_t;

endpackage

// ===== src/rbs_if.sv =====
// Ray input and hit result channel interfaces.
`timescale 1ns / 1ps

interface rbs_ray_if #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;

  modport source (output valid, origin_x, origin_y, dir_x, dir_y, input ready);
  modport sink   (input valid, origin_x, origin_y, dir_x, dir_y, output ready);
endinterface

interface rbs_hit_if #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic        [COORD_WIDTH-2:0] distance;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, hit, distance, point_x, point_y, input ready);
  modport sink   (input valid, hit, distance, point_x, point_y, output ready);
endinterface

// ===== src/rbs_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and passes the rest on.
`timescale 1ns / 1ps

module rbs_div_cell #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
  parameter int QUO_WIDTH   = rbs_pkg::QUO_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_WIDTH-1:0] rem_in,
  input  logic [QUO_WIDTH-1:0]   num_in,
  input  logic [COORD_WIDTH-1:0] den_in,
  input  logic [QUO_WIDTH-1:0]   quo_in,
  output logic [COORD_WIDTH-1:0] rem_out,
  output logic [QUO_WIDTH-1:0]   num_out,
  output logic [COORD_WIDTH-1:0] den_out,
  output logic [QUO_WIDTH-1:0]   quo_out
);

  logic [COORD_WIDTH:0] trial;
  logic [COORD_WIDTH:0] diff;
  logic                 ge;

  // Bring down the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_in, num_in[QUO_WIDTH-1]};
    diff  = trial - {1'b0, den_in};
    ge    = (trial >= {1'b0, den_in});
  end

  // Remainder stays below the divisor, so it fits COORD_WIDTH bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
      num_out <= {num_in[QUO_WIDTH-2:0], 1'b0};
      den_out <= den_in;
      quo_out <= {quo_in[QUO_WIDTH-2:0], ge};
    end
  end

endmodule

// ===== src/rbs_div_row.sv =====
// Row of division cells: one quotient bit per cell, one new division per cycle while en is high.
`timescale 1ns / 1ps

module rbs_div_row #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
  parameter int QUO_WIDTH   = rbs_pkg::QUO_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [QUO_WIDTH-1:0]   num,
  input  logic [COORD_WIDTH-1:0] den,
  output logic [QUO_WIDTH-1:0]   quo
);

  // Inputs of each cell
  logic [COORD_WIDTH-1:0] rem_c [QUO_WIDTH];
  logic [QUO_WIDTH-1:0]   num_c [QUO_WIDTH];
  logic [COORD_WIDTH-1:0] den_c [QUO_WIDTH];
  logic [QUO_WIDTH-1:0]   quo_c [QUO_WIDTH];

  assign rem_c[0] = '0;
  assign num_c[0] = num;
  assign den_c[0] = den;
  assign quo_c[0] = '0;

  for (genvar i = 0; i < QUO_WIDTH; i++) begin : g_cell
    if (i < QUO_WIDTH - 1) begin : g_mid
      rbs_div_cell #(.COORD_WIDTH(COORD_WIDTH), .QUO_WIDTH(QUO_WIDTH)) u_cell (
        .clk     (clk),
        .en      (en),
        .rem_in  (rem_c[i]),
        .num_in  (num_c[i]),
        .den_in  (den_c[i]),
        .quo_in  (quo_c[i]),
        .rem_out (rem_c[i+1]),
        .num_out (num_c[i+1]),
        .den_out (den_c[i+1]),
        .quo_out (quo_c[i+1])
      );
    end else begin : g_last
      rbs_div_cell #(.COORD_WIDTH(COORD_WIDTH), .QUO_WIDTH(QUO_WIDTH)) u_cell (
        .clk     (clk),
        .en      (en),
        .rem_in  (rem_c[i]),
        .num_in  (num_c[i]),
        .den_in  (den_c[i]),
        .quo_in  (quo_c[i]),
        .rem_out (),
        .num_out (),
        .den_out (),
        .quo_out (quo)
      );
    end
  end

endmodule

// ===== src/ray_box_slab_intersect.sv =====
// Top level: 2D ray versus axis-aligned box slab test, fully pipelined.
//
//   channel | kind          | fields
//   --------+---------------+-----------------------------------------------
//   ray     | valid/ready   | origin_x, origin_y, dir_x, dir_y
//   res     | valid/ready   | hit, distance, point_x, point_y
//   apb     | APB write/read| box_left, box_bottom, box_width, box_height
//
// One ray per cycle unless stalled (default format Q16.16). Rays pass stage A,
// the four division rows (one quotient bit per cell), stages B-E, output register.
// The whole pipeline stalls while a result sits in the output register
// and res.ready is low; ray.ready follows that stall.
// Synchronous reset clears all valid bits and the box registers; ray.ready is
// held low during reset.
`timescale 1ns / 1ps

module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  rbs_ray_if.sink                               ray,
  rbs_hit_if.source                             res,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0]  paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                  pready
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = (W > 32) ? 64 : 32;
  localparam int AW  = (W > 32) ? 5 : 4;
  localparam int QW  = W + 1 + F;
  localparam int TW  = ((QW > rbs_pkg::TINF_LOG2) ? QW : rbs_pkg::TINF_LOG2) + 2;
  localparam int GW  = 4 * W;
  localparam int SBW = GW + 7;
  localparam int MW  = 2 * W - 1;
  localparam int PW  = 2 * W - F + 2;

  localparam logic [TW-1:0]        TCAP  = TW'(1) << rbs_pkg::TCAP_LOG2;
  localparam logic signed [TW-1:0] TINF  = TW'(1) << rbs_pkg::TINF_LOG2;
  localparam logic signed [TW-1:0] DMAXT = (TW'(1) << (W - 1)) - TW'(1);
  localparam logic signed [PW-1:0] PMAX  = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic signed [PW-1:0] PMIN  = -(PW'(1) << (W - 1));

  // ---------------------------------------------------------------
  // Configuration registers
  logic signed [W-1:0] box_left;
  logic signed [W-1:0] box_bottom;
  logic        [W-2:0] box_width;
  logic        [W-2:0] box_height;
  logic                cfg_wr;
  rbs_pkg::cfg_reg_t   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = rbs_pkg::cfg_reg_t'(paddr[AW-1:AW-2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_bottom <= '0;
      box_width  <= '0;
      box_height <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rbs_pkg::REG_BOX_LEFT:   box_left   <= pwdata[W-1:0];
        rbs_pkg::REG_BOX_BOTTOM: box_bottom <= pwdata[W-1:0];
        rbs_pkg::REG_BOX_WIDTH:  box_width  <= pwdata[W-2:0];
        rbs_pkg::REG_BOX_HEIGHT: box_height <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rbs_pkg::REG_BOX_LEFT:   prdata = DW'($unsigned(box_left));
      rbs_pkg::REG_BOX_BOTTOM: prdata = DW'($unsigned(box_bottom));
      rbs_pkg::REG_BOX_WIDTH:  prdata = DW'(box_width);
      rbs_pkg::REG_BOX_HEIGHT: prdata = DW'(box_height);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Global advance: hold everything while the output waits
  logic en;
  assign en        = !res.valid || res.ready;
  assign ray.ready = en && !rst;

  // ---------------------------------------------------------------
  // Stage A: edge differences, slab order by direction sign
  logic signed [W-1:0]   ax_lo   [2];
  logic        [W-2:0]   ax_sz   [2];
  logic signed [W-1:0]   ax_o    [2];
  logic signed [W-1:0]   ax_d    [2];
  logic signed [W+1:0]   ax_elo  [2];
  logic signed [W+1:0]   ax_ehi  [2];
  logic signed [W+1:0]   ax_eo   [2];
  logic signed [W+1:0]   ax_dlo  [2];
  logic signed [W+1:0]   ax_dhi  [2];
  logic signed [W+1:0]   ax_nn   [2];
  logic signed [W+1:0]   ax_nf   [2];
  logic        [W+1:0]   ax_ann  [2];
  logic        [W+1:0]   ax_anf  [2];
  logic        [W:0]     ax_ad   [2];
  logic                  ax_par  [2];
  logic                  ax_in   [2];
  logic                  ax_negn [2];
  logic                  ax_negf [2];
  logic                  miss0;

  assign ax_lo[0] = box_left;
  assign ax_lo[1] = box_bottom;
  assign ax_sz[0] = box_width;
  assign ax_sz[1] = box_height;
  assign ax_o[0]  = ray.origin_x;
  assign ax_o[1]  = ray.origin_y;
  assign ax_d[0]  = ray.dir_x;
  assign ax_d[1]  = ray.dir_y;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ax_elo[k]  = {{2{ax_lo[k][W-1]}}, ax_lo[k]};
      ax_ehi[k]  = ax_elo[k] + $signed({3'b000, ax_sz[k]});
      ax_eo[k]   = {{2{ax_o[k][W-1]}}, ax_o[k]};
      ax_dlo[k]  = ax_elo[k] - ax_eo[k];
      ax_dhi[k]  = ax_ehi[k] - ax_eo[k];
      ax_nn[k]   = ax_d[k][W-1] ? ax_dhi[k] : ax_dlo[k];
      ax_nf[k]   = ax_d[k][W-1] ? ax_dlo[k] : ax_dhi[k];
      ax_ann[k]  = ax_nn[k][W+1] ? $unsigned(-ax_nn[k]) : $unsigned(ax_nn[k]);
      ax_anf[k]  = ax_nf[k][W+1] ? $unsigned(-ax_nf[k]) : $unsigned(ax_nf[k]);
      ax_ad[k]   = ax_d[k][W-1] ? $unsigned(-{ax_d[k][W-1], ax_d[k]})
                                : $unsigned({ax_d[k][W-1], ax_d[k]});
      ax_negn[k] = ax_nn[k][W+1] ^ ax_d[k][W-1];
      ax_negf[k] = ax_nf[k][W+1] ^ ax_d[k][W-1];
      ax_par[k]  = (ax_d[k] == '0);
      ax_in[k]   = (ax_eo[k] >= ax_elo[k]) && (ax_eo[k] <= ax_ehi[k]);
    end
    // Both parallel, or a parallel axis with the origin outside its slab
    miss0 = (ax_par[0] && ax_par[1]) || (ax_par[0] && !ax_in[0]) ||
            (ax_par[1] && !ax_in[1]);
  end

  logic             a_vld;
  logic [QW-1:0]    a_num [4];
  logic [W-1:0]     a_den [2];
  logic [SBW-1:0]   a_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        a_num[2*k]   <= {ax_ann[k][W:0], {F{1'b0}}};
        a_num[2*k+1] <= {ax_anf[k][W:0], {F{1'b0}}};
        a_den[k]     <= ax_ad[k][W-1:0];
      end
      a_sb <= {ray.origin_x, ray.origin_y, ray.dir_x, ray.dir_y, miss0,
               ax_par[0], ax_par[1], ax_negn[0], ax_negf[0], ax_negn[1], ax_negf[1]};
    end
  end

  // ---------------------------------------------------------------
  // Division rows: lanes are x near, x far, y near, y far
  logic [QW-1:0] row_q [4];

  for (genvar j = 0; j < 4; j++) begin : g_row
    rbs_div_row #(.COORD_WIDTH(W), .QUO_WIDTH(QW)) u_row (
      .clk (clk),
      .en  (en),
      .num (a_num[j]),
      .den (a_den[j/2]),
      .quo (row_q[j])
    );
  end

  // Side data shift line, aligned with the rows
  logic           sb_vld [QW];
  logic [SBW-1:0] sb     [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) sb_vld[i] <= 1'b0;
    end else if (en) begin
      sb_vld[0] <= a_vld;
      for (int i = 1; i < QW; i++) sb_vld[i] <= sb_vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= a_sb;
      for (int i = 1; i < QW; i++) sb[i] <= sb[i-1];
    end
  end

  // ---------------------------------------------------------------
  // Stage B: signed, capped ray parameters
  logic [SBW-1:0]        sb_end;
  logic                  sb_par [2];
  logic                  sb_neg [4];
  logic [TW-1:0]         q_mag  [4];
  logic signed [TW-1:0]  q_t    [4];

  assign sb_end    = sb[QW-1];
  assign sb_par[0] = sb_end[5];
  assign sb_par[1] = sb_end[4];
  assign sb_neg[0] = sb_end[3];
  assign sb_neg[1] = sb_end[2];
  assign sb_neg[2] = sb_end[1];
  assign sb_neg[3] = sb_end[0];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      q_mag[j] = TW'(row_q[j]);
      if (q_mag[j] > TCAP) q_mag[j] = TCAP;
      q_t[j] = sb_neg[j] ? -$signed(q_mag[j]) : $signed(q_mag[j]);
      // Parallel axis: unbounded interval
      if (sb_par[j/2]) q_t[j] = (j % 2 == 0) ? -TINF : TINF;
    end
  end

  logic                 b_vld;
  logic signed [TW-1:0] b_t [4];
  logic                 b_miss;
  logic [GW-1:0]        b_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= sb_vld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) b_t[j] <= q_t[j];
      b_miss <= sb_end[6];
      b_geo  <= sb_end[SBW-1:7];
    end
  end

  // ---------------------------------------------------------------
  // Stage C: slab overlap, joint entry and exit
  logic                 c_vld;
  logic                 c_miss;
  logic signed [TW-1:0] c_tn;
  logic signed [TW-1:0] c_tf;
  logic [GW-1:0]        c_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_miss <= b_miss || (b_t[0] > b_t[3]) || (b_t[2] > b_t[1]);
      c_tn   <= (b_t[2] > b_t[0]) ? b_t[2] : b_t[0];
      c_tf   <= (b_t[3] < b_t[1]) ? b_t[3] : b_t[1];
      c_geo  <= b_geo;
    end
  end

  // ---------------------------------------------------------------
  // Stage D: nearest nonnegative parameter, saturated distance
  logic signed [TW-1:0] t_sel;
  logic                 d_vld;
  logic                 d_miss;
  logic [W-2:0]         d_dist;
  logic [GW-1:0]        d_geo;

  assign t_sel = (c_tn < 0) ? c_tf : c_tn;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_miss <= c_miss || (t_sel < 0);
      d_dist <= (t_sel > DMAXT) ? {(W-1){1'b1}} : t_sel[W-2:0];
      d_geo  <= c_geo;
    end
  end

  // ---------------------------------------------------------------
  // Stage E: |dir| * distance per axis
  logic signed [W-1:0] d_ox, d_oy, d_dx, d_dy;
  logic [W-1:0]        d_adx, d_ady;

  assign {d_ox, d_oy, d_dx, d_dy} = d_geo;
  assign d_adx = d_dx[W-1] ? $unsigned(-d_dx) : $unsigned(d_dx);
  assign d_ady = d_dy[W-1] ? $unsigned(-d_dy) : $unsigned(d_dy);

  logic                e_vld;
  logic                e_miss;
  logic [W-2:0]        e_dist;
  logic [MW-1:0]       e_px, e_py;
  logic                e_nx, e_ny;
  logic signed [W-1:0] e_ox, e_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_miss <= d_miss;
      e_dist <= d_dist;
      e_px   <= MW'(d_adx) * MW'(d_dist);
      e_py   <= MW'(d_ady) * MW'(d_dist);
      e_nx   <= d_dx[W-1];
      e_ny   <= d_dy[W-1];
      e_ox   <= d_ox;
      e_oy   <= d_oy;
    end
  end

  // ---------------------------------------------------------------
  // Output register: hit point with saturation
  logic signed [PW-1:0] px_full, py_full;
  logic signed [W-1:0]  px_sat, py_sat;

  always_comb begin
    px_full = e_nx ? PW'(e_ox) - $signed(PW'(e_px >> F))
                   : PW'(e_ox) + $signed(PW'(e_px >> F));
    py_full = e_ny ? PW'(e_oy) - $signed(PW'(e_py >> F))
                   : PW'(e_oy) + $signed(PW'(e_py >> F));
    if (px_full > PMAX)      px_sat = PMAX[W-1:0];
    else if (px_full < PMIN) px_sat = PMIN[W-1:0];
    else                     px_sat = px_full[W-1:0];
    if (py_full > PMAX)      py_sat = PMAX[W-1:0];
    else if (py_full < PMIN) py_sat = PMIN[W-1:0];
    else                     py_sat = py_full[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit      <= !e_miss;
      res.distance <= e_miss ? '0 : e_dist;
      res.point_x  <= e_miss ? '0 : px_sat;
      res.point_y  <= e_miss ? '0 : py_sat;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |->
      res.distance == '0 && res.point_x == '0 && res.point_y == '0)
    else $error("miss transaction carries nonzero payload");

  a_take_ray: assert property (@(posedge clk) disable iff (rst)
    ray.valid && ray.ready |=> a_vld)
    else $error("accepted ray did not enter the first stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(a_vld) && $stable(sb_vld[QW-1]) && $stable(e_vld))
    else $error("pipeline moved during output stall");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res.valid && !a_vld)
    else $error("valid bits not cleared by reset");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the 2D ray versus box slab test.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 60;
  localparam longint LIMIT = 2000000;
  localparam longint T_INF = longint'(1) <<< rbs_pkg::TINF_LOG2;
  localparam longint T_CAP = longint'(1) <<< rbs_pkg::TCAP_LOG2;

  typedef struct {
    logic signed [31:0] ox, oy, dx, dy;
  } ray_t;

  typedef struct {
    logic               hit;
    logic        [30:0] distance;
    logic signed [31:0] px, py;
  } hit_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rbs_ray_if ray ();
  rbs_hit_if res ();

  ray_box_slab_intersect uut (
    .clk(clk), .rst(rst), .ray(ray.sink), .res(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // box registers as the checker sees them
  longint box_x = 0, box_y = 0, box_w = 0, box_h = 0;

  ray_t   pending_rays[$];
  hit_t   expected_hits[$];
  int     errors = 0;
  longint cycles = 0;

  // exact fixed-point quotient (num << 16) / den, truncated toward zero, capped at T_CAP
  function automatic longint fx_div(longint num, longint den);
    longint un, ud, q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un <<< 16) / ud;
    if (q > T_CAP) q = T_CAP;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // t interval for one axis; returns 0 when that axis alone misses
  function automatic bit axis_span(longint lo, longint size, longint o, longint d,
                                   output longint tn, output longint tf);
    longint hi;
    hi = lo + size;
    if (d == 0) begin
      tn = -T_INF;
      tf = T_INF;
      return (o >= lo) && (o <= hi);
    end
    if (d > 0) begin
      tn = fx_div(lo - o, d);
      tf = fx_div(hi - o, d);
    end else begin
      tn = fx_div(hi - o, d);
      tf = fx_div(lo - o, d);
    end
    return 1;
  endfunction

  // origin + dir * t, product truncated toward zero, then saturated
  function automatic logic signed [31:0] hit_coord(longint o, longint d, longint t);
    longint m, p;
    m = (((d < 0) ? -d : d) * t) >>> 16;
    p = (d < 0) ? o - m : o + m;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic hit_t predict_hit(ray_t r);
    hit_t h;
    longint ox, oy, dx, dy, txn, txf, tyn, tyf, tn, tf, t;
    h = '{hit: 0, distance: '0, px: '0, py: '0};
    ox = r.ox; oy = r.oy; dx = r.dx; dy = r.dy;
    if (dx == 0 && dy == 0) return h;
    if (!axis_span(box_x, box_w, ox, dx, txn, txf)) return h;
    if (!axis_span(box_y, box_h, oy, dy, tyn, tyf)) return h;
    if (txn > tyf || tyn > txf) return h;
    tn = (tyn > txn) ? tyn : txn;
    tf = (tyf < txf) ? tyf : txf;
    t = tn;
    if (t < 0) begin
      t = tf;
      if (t < 0) return h;
    end
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    h.hit = 1;
    h.distance = t[30:0];
    h.px = hit_coord(ox, dx, t);
    h.py = hit_coord(oy, dy, t);
    return h;
  endfunction

  // mostly short gaps, some long, with stretches of none
  bit no_gaps = 0;
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ray source
  int ray_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      ray.valid <= 0;
    end else if (!ray.valid || ray.ready) begin
      if (ray_gap > 0) begin
        ray_gap <= ray_gap - 1;
        ray.valid <= 0;
      end else if (pending_rays.size() > 0) begin
        ray_t r;
        r = pending_rays.pop_front();
        expected_hits.push_back(predict_hit(r));
        ray.origin_x <= r.ox;
        ray.origin_y <= r.oy;
        ray.dir_x <= r.dx;
        ray.dir_y <= r.dy;
        ray.valid <= 1;
        ray_gap <= pick_gap();
      end else begin
        ray.valid <= 0;
      end
    end
  end

  // result sink with random backpressure
  int res_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_hits.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          hit_t e;
          e = expected_hits.pop_front();
          if (res.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, res.hit);
            errors++;
          end
          if (res.distance !== e.distance) begin
            $error("distance: expected %0d, got %0d", e.distance, res.distance);
            errors++;
          end
          if (res.point_x !== e.px) begin
            $error("point_x: expected %0d, got %0d", e.px, res.point_x);
            errors++;
          end
          if (res.point_y !== e.py) begin
            $error("point_y: expected %0d, got %0d", e.py, res.point_y);
            errors++;
          end
        end
      end
      if (res_gap > 0) begin
        res_gap <= res_gap - 1;
        res.ready <= 0;
      end else begin
        res.ready <= 1;
        res_gap <= pick_gap();
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic write_reg(rbs_pkg::cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      rbs_pkg::REG_BOX_LEFT:   box_x = longint'($signed(value));
      rbs_pkg::REG_BOX_BOTTOM: box_y = longint'($signed(value));
      rbs_pkg::REG_BOX_WIDTH:  box_w = value[30:0];
      rbs_pkg::REG_BOX_HEIGHT: box_h = value[30:0];
      default: ;
    endcase
  endtask

  task automatic set_box(logic [31:0] l, logic [31:0] b, logic [31:0] w, logic [31:0] h);
    write_reg(rbs_pkg::REG_BOX_LEFT, l);
    write_reg(rbs_pkg::REG_BOX_BOTTOM, b);
    write_reg(rbs_pkg::REG_BOX_WIDTH, w);
    write_reg(rbs_pkg::REG_BOX_HEIGHT, h);
  endtask

  task automatic drain();
    while (pending_rays.size() > 0 || expected_hits.size() > 0 || ray.valid)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  // signed value of random magnitude
  function automatic logic signed [31:0] rnd_scaled();
    return $signed(rnd32()) >>> $urandom_range(0, 31);
  endfunction

  // coordinate around a box span, occasionally anywhere
  function automatic logic signed [31:0] near_span(longint lo, longint size);
    longint v;
    if ($urandom_range(0, 9) == 0) return rnd32();
    v = lo + longint'($urandom_range(0, 1000)) * (size + 65536) / 500
        - (size + 65536) / 2;
    return v[31:0];
  endfunction

  task automatic queue_rays(int count);
    ray_t r;
    longint tx, ty;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r = '{rnd32(), rnd32(), rnd_scaled(), rnd_scaled()};
        end
        2: begin
          // axis-parallel ray
          r = '{near_span(box_x, box_w), near_span(box_y, box_h), rnd_scaled(), '0};
          if ($urandom_range(0, 1)) begin
            r.dy = r.dx;
            r.dx = '0;
          end
        end
        default: begin
          // aimed at a point in or near the box
          r.ox = near_span(box_x, box_w);
          r.oy = near_span(box_y, box_h);
          tx = box_x + box_w * $urandom_range(0, 100) / 100;
          ty = box_y + box_h * $urandom_range(0, 100) / 100;
          tx = (tx - longint'(r.ox)) >>> $urandom_range(0, 8);
          ty = (ty - longint'(r.oy)) >>> $urandom_range(0, 8);
          if ($urandom_range(0, 7) == 0) begin
            tx = -tx;
            ty = -ty;
          end
          r.dx = tx[31:0];
          r.dy = ty[31:0];
        end
      endcase
      pending_rays.push_back(r);
    end
  endtask

  localparam logic [31:0] SMAX = 32'h7fffffff;
  localparam logic [31:0] SMIN = 32'h80000000;
  localparam logic [31:0] ONE  = 32'h00010000;

  initial begin
    ray.valid = 0;
    ray.origin_x = '0;
    ray.origin_y = '0;
    ray.dir_x = '0;
    ray.dir_y = '0;
    res.ready = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // reset box: a single point at the origin
    pending_rays.push_back('{'0, '0, ONE, ONE});
    pending_rays.push_back('{-ONE, -ONE, ONE, ONE});
    queue_rays(30);
    drain();

    // unit-ish box, directed cases
    set_box(32'(-2 * ONE), 32'(-ONE), 32'(4 * ONE), 32'(2 * ONE));
    pending_rays.push_back('{'0, '0, '0, '0});             // zero direction
    pending_rays.push_back('{'0, '0, ONE, '0});            // parallel, inside slab
    pending_rays.push_back('{'0, 32'(5 * ONE), ONE, '0});  // parallel, outside slab
    pending_rays.push_back('{'0, 32'(ONE), ONE, '0});      // parallel, on top edge
    pending_rays.push_back('{32'(-2 * ONE), '0, '0, ONE}); // parallel, on left edge
    pending_rays.push_back('{32'(-8 * ONE), '0, ONE, '0}); // enters from the left
    pending_rays.push_back('{32'(8 * ONE), '0, ONE, '0});  // box behind origin
    pending_rays.push_back('{32'(8 * ONE), '0, -ONE, '0}); // negative direction
    pending_rays.push_back('{'0, '0, ONE, ONE});           // origin inside
    pending_rays.push_back('{32'(-8 * ONE), 32'(8 * ONE), ONE, -ONE}); // hits top edge
    pending_rays.push_back('{SMIN, SMIN, 32'd1, 32'd1});   // tiny direction
    pending_rays.push_back('{SMAX, SMAX, SMIN, SMIN});
    pending_rays.push_back('{SMIN, '0, SMAX, '0});
    pending_rays.push_back('{SMAX, SMIN, 32'hffffffff, 32'd1});
    pending_rays.push_back('{SMIN, SMAX, SMAX, SMIN});
    pending_rays.push_back('{'0, 32'(-8 * ONE), 32'hffffffff, SMAX});
    queue_rays(400);
    drain();

    // widest box, corner at the negative extreme
    set_box(SMIN, SMIN, SMAX, SMAX);
    pending_rays.push_back('{SMAX, SMAX, SMIN, SMIN});
    pending_rays.push_back('{SMIN, SMIN, '0, 32'd1});
    pending_rays.push_back('{SMAX, '0, 32'd1, '0});
    queue_rays(350);
    drain();

    // box at the positive extreme, extending past the coordinate range
    set_box(SMAX, SMAX, SMAX, 32'd0);
    pending_rays.push_back('{SMAX, SMAX, 32'd1, '0});
    pending_rays.push_back('{SMIN, SMIN, SMAX, SMAX});
    queue_rays(300);
    drain();

    // random boxes; the top bit of the height write is ignored by the block
    repeat (4) begin
      set_box(rnd_scaled(), rnd_scaled(), rnd32() >> $urandom_range(1, 31),
              {1'($urandom_range(0, 1)), 31'(rnd32() >> $urandom_range(1, 31))});
      queue_rays(160);
      drain();
    end

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rbs_pkg.sv
src/rbs_if.sv
src/rbs_div_cell.sv
src/rbs_div_row.sv
src/ray_box_slab_intersect.sv
bench/testbench.sv
